>>> design/modexp_pkg.sv
package modexp_pkg;

  // two serial multiplier lanes run side by side
  localparam int NUM_LANES = 2;

  // lane that squares the running base
  localparam logic [0:0] LANE_SQ = 1'b0;
  // lane that multiplies the accumulator by the running base
  localparam logic [0:0] LANE_ACC = 1'b1;

  // modulus after reset, before any configuration write
  localparam logic [30:0] MOD_RESET = 31'd1000000007;

endpackage

>>> design/modexp_in_if.sv
interface modexp_in_if #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] base;
  logic [EXP_BITS-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

>>> design/modexp_out_if.sv
interface modexp_out_if #(
  parameter int MOD_BITS = 31
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface

>>> design/modexp_cfg_if.sv
interface modexp_cfg_if #(
  parameter int MOD_BITS = 31
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

>>> design/modular_exponentiation.sv
// modular exponentiation, power = base ** exponent mod modulus
//
// in_chan carries one item (base, exponent); out_chan returns one power per
// item, in 0 to modulus-1 (0 for modulus 0). cfg_chan writes the modulus;
// it is always ready; the user must write it only while no item is in flight,
// not enforced by the block. a modulus below two skips all work, gives zero.
//
// the base is first reduced bit-serially, then each exponent bit up to the
// highest set one costs a setup step in S_NEXT and a multiplication: two
// shift-and-add multipliers (square and accumulate) run in parallel, one
// doubling or one add step per cycle, each followed by one conditional
// subtract of the modulus. one item is worked on at a time; the next one is
// taken in the cycle after the current result is loaded into the output
// register.
//
// reset (rst_n low, synchronous) empties the block and loads the modulus
// 1000000007. a stalled receiver holds the result in the output register;
// a second finished result waits in the datapath until that register frees.
module modular_exponentiation #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  modexp_cfg_if.sink   cfg_chan,
  modexp_in_if.sink    in_chan,
  modexp_out_if.source out_chan
);
  import modexp_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_DBL,
    S_ADD
  } state_t;

  state_t              state_r;
  logic [MOD_BITS-1:0] mod_r;
  logic [EXP_BITS-1:0] e_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MOD_BITS-1:0] sq_r;
  logic [MOD_BITS-1:0] acc_r;
  logic [MOD_BITS-1:0] power_r;
  logic                out_valid_r;

  // per lane: partial remainder, multiplicand, multiplier shift register
  logic [MOD_BITS-1:0] r_r [NUM_LANES];
  logic [MOD_BITS-1:0] a_r [NUM_LANES];
  logic [MOD_BITS-1:0] b_r [NUM_LANES];

  logic [MOD_BITS:0]   t_sum [NUM_LANES];
  logic [MOD_BITS-1:0] r_nxt [NUM_LANES];
  logic                mod_small;
  logic                cnt_end;
  logic                out_load;

  assign mod_small = (mod_r < MOD_BITS'(2));
  assign cnt_end   = (cnt_r == CNT_LAST);

  // finished power moves into a free (or freeing) output register
  assign out_load = (state_r == S_NEXT) && (e_r == '0) &&
                    (!out_valid_r || out_chan.ready);

  // one lane step: double (shifting in a base bit while reducing) or add,
  // then one conditional subtract keeps the remainder below the modulus
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (state_r == S_ADD) begin
        t_sum[i] = {1'b0, r_r[i]} +
                   (b_r[i][MOD_BITS-1] ? {1'b0, a_r[i]} : '0);
      end else begin
        t_sum[i] = {r_r[i], (state_r == S_REDUCE) ? b_r[i][MOD_BITS-1] : 1'b0};
      end
      if (t_sum[i] >= {1'b0, mod_r}) begin
        r_nxt[i] = MOD_BITS'(t_sum[i] - {1'b0, mod_r});
      end else begin
        r_nxt[i] = t_sum[i][MOD_BITS-1:0];
      end
    end
  end

  // handshakes
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.power = power_r;

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_BITS'(MOD_RESET);
    end else begin
      if (cfg_chan.valid) begin
        mod_r <= cfg_chan.modulus;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cnt_r          <= '0;
            r_r[LANE_SQ]   <= '0;
            b_r[LANE_SQ]   <= in_chan.base;
            if (mod_small) begin
              // no residue to work on: finish at once with zero
              e_r     <= '0;
              acc_r   <= '0;
              state_r <= S_NEXT;
            end else begin
              e_r     <= in_chan.exponent;
              acc_r   <= MOD_BITS'(1);
              state_r <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          r_r[LANE_SQ] <= r_nxt[LANE_SQ];
          b_r[LANE_SQ] <= b_r[LANE_SQ] << 1;
          if (cnt_end) begin
            sq_r    <= r_nxt[LANE_SQ];
            cnt_r   <= '0;
            state_r <= S_NEXT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_NEXT: begin
          if (e_r == '0) begin
            // done: hand over once the output register is free
            if (out_load) begin
              power_r <= acc_r;
              state_r <= S_IDLE;
            end
          end else begin
            a_r[LANE_SQ]  <= sq_r;
            a_r[LANE_ACC] <= sq_r;
            b_r[LANE_SQ]  <= sq_r;
            b_r[LANE_ACC] <= acc_r;
            r_r[LANE_SQ]  <= '0;
            r_r[LANE_ACC] <= '0;
            cnt_r         <= '0;
            state_r       <= S_DBL;
          end
        end
        S_DBL: begin
          r_r[LANE_SQ]  <= r_nxt[LANE_SQ];
          r_r[LANE_ACC] <= r_nxt[LANE_ACC];
          state_r       <= S_ADD;
        end
        S_ADD: begin
          r_r[LANE_SQ]  <= r_nxt[LANE_SQ];
          r_r[LANE_ACC] <= r_nxt[LANE_ACC];
          b_r[LANE_SQ]  <= b_r[LANE_SQ] << 1;
          b_r[LANE_ACC] <= b_r[LANE_ACC] << 1;
          if (cnt_end) begin
            sq_r <= r_nxt[LANE_SQ];
            if (e_r[0]) begin
              acc_r <= r_nxt[LANE_ACC];
            end
            e_r     <= e_r >> 1;
            state_r <= S_NEXT;
          end else begin
            cnt_r   <= cnt_r + CNT_W'(1);
            state_r <= S_DBL;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // residues stay reduced between exponent bits
  a_residues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT && !mod_small && e_r != '0) |->
      (sq_r < mod_r && acc_r < mod_r))
    else $error("running square or accumulator not reduced");

  // lane remainders stay reduced inside a multiplication
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DBL || state_r == S_ADD) |->
      (r_r[LANE_SQ] < mod_r && r_r[LANE_ACC] < mod_r))
    else $error("lane remainder not reduced");

  // a delivered power is a residue of the modulus
  a_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !mod_small) |-> (power_r < mod_r))
    else $error("power out of range");

  // an accepted item starts either the base reduction or the finish path
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=>
      (state_r == S_REDUCE || state_r == S_NEXT))
    else $error("item accepted without starting");

  // the bit counter never runs past the operand width
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REDUCE || state_r == S_DBL || state_r == S_ADD) |->
      (cnt_r <= CNT_LAST))
    else $error("bit counter overrun");

endmodule
